FILE: sv/pgc_pkg.sv
// Shared constants, codes and memory port types of the palette and gamma lookup table.
package pgc_pkg;

   localparam int PGC_PALETTE_DEPTH = 256;
   localparam int PGC_GAMMA_ENTRIES = 256;

   // Action codes of a request word.
   localparam logic [1:0] ACT_GAMMA_WR = 2'd0;
   localparam logic [1:0] ACT_PAL_WR   = 2'd1;
   localparam logic [1:0] ACT_PAL_RD   = 2'd2;
   localparam logic [1:0] ACT_NONE     = 2'd3;

   // Status codes of a response word.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_WR_REJ = 2'd1;
   localparam logic [1:0] STATUS_RD_REJ = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GRAY_MAPPING  = 3'd0;
   localparam logic [2:0] CSR_GAMMA_ENABLE  = 3'd1;
   localparam logic [2:0] CSR_GAMMA_WIDTH   = 3'd2;
   localparam logic [2:0] CSR_THREE_CHANNEL = 3'd3;
   localparam logic [2:0] CSR_DIRECT_MODE   = 3'd4;

   // Gamma table selects.
   localparam logic [1:0] TBL_RED   = 2'd0;
   localparam logic [1:0] TBL_GREEN = 2'd1;
   localparam logic [1:0] TBL_BLUE  = 2'd2;

   // Luminance weights, sixteen fractional bits.
   localparam logic [15:0] LUMA_R = 16'h4ccc;
   localparam logic [15:0] LUMA_G = 16'h970a;
   localparam logic [15:0] LUMA_B = 16'h1c29;

   localparam logic [3:0] GAMMA_WIDTH_MAX = 4'd8;

   typedef struct packed {
      logic        wr_en;
      logic [7:0]  wr_index;
      logic [23:0] wr_data;
      logic [7:0]  rd_index;
   } pal_port_type;

   typedef struct packed {
      logic [2:0] wr_en;
      logic [7:0] wr_index;
      logic [7:0] wr_data;
      logic [1:0] rd_table;
      logic [7:0] rd_index;
   } gamma_port_type;

endpackage

FILE: sv/pgc_if.sv
// Handshake channel interfaces for requests, responses and configuration writes.
interface pgc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  index;
   logic [1:0]  channel;
   logic [15:0] red_in;
   logic [15:0] green_in;
   logic [15:0] blue_in;
   logic [7:0]  gamma_value;

   modport source (output valid, action, index, channel, red_in, green_in, blue_in,
                   gamma_value, input ready);
   modport sink (input valid, action, index, channel, red_in, green_in, blue_in,
                 gamma_value, output ready);
endinterface

interface pgc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] red_out;
   logic [15:0] green_out;
   logic [15:0] blue_out;
   logic [1:0]  status;

   modport source (output valid, red_out, green_out, blue_out, status, input ready);
   modport sink (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

interface pgc_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [3:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/pgc_palette_mem.sv
// Palette memory: one write and one registered read per cycle, 24-bit RGB entries.
module pgc_palette_mem #(
   parameter int PALETTE_DEPTH = pgc_pkg::PGC_PALETTE_DEPTH
) (
   input  logic                 clock,
   input  pgc_pkg::pal_port_type port_in,
   output logic [23:0]          rd_data
);
   import pgc_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [23:0] mem [PALETTE_DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (port_in.wr_en) begin
         mem[port_in.wr_index[AW-1:0]] <= port_in.wr_data;
      end
      rd_data_ff <= mem[port_in.rd_index[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/pgc_gamma_mem.sv
// Gamma memories: three tables with their own write enables and a shared registered read.
module pgc_gamma_mem #(
   parameter int GAMMA_ENTRIES = pgc_pkg::PGC_GAMMA_ENTRIES
) (
   input  logic                   clock,
   input  pgc_pkg::gamma_port_type port_in,
   output logic [7:0]             rd_data
);
   import pgc_pkg::*;

   localparam int AW = $clog2(GAMMA_ENTRIES);

   logic [7:0] tbl_q [3];
   logic [1:0] sel_ff;

   for (genvar t = 0; t < 3; t++) begin : g_tbl
      logic [7:0] mem [GAMMA_ENTRIES];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (port_in.wr_en[t]) begin
            mem[port_in.wr_index[AW-1:0]] <= port_in.wr_data;
         end
         rd_ff <= mem[port_in.rd_index[AW-1:0]];
      end

      assign tbl_q[t] = rd_ff;
   end

   always_ff @(posedge clock) begin
      sel_ff <= port_in.rd_table;
   end

   always_comb begin
      case (sel_ff)
         TBL_GREEN: rd_data = tbl_q[1];
         TBL_BLUE:  rd_data = tbl_q[2];
         default:   rd_data = tbl_q[0];
      endcase
   end

endmodule

FILE: sv/pgc_seq.sv
// Sequencer: configuration registers, clearing pass and the read-modify-write walk per word.
module pgc_seq #(
   parameter int PALETTE_DEPTH = pgc_pkg::PGC_PALETTE_DEPTH,
   parameter int GAMMA_ENTRIES = pgc_pkg::PGC_GAMMA_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   pgc_req_if.sink                 req_bus,
   pgc_rsp_if.source               rsp_bus,
   pgc_csr_if.sink                 csr_bus,
   output pgc_pkg::pal_port_type   pal_port,
   input  logic [23:0]             pal_rd_data,
   output pgc_pkg::gamma_port_type gamma_port,
   input  logic [7:0]              gamma_rd_data
);
   import pgc_pkg::*;

   localparam int SWEEP = (PALETTE_DEPTH > GAMMA_ENTRIES) ? PALETTE_DEPTH : GAMMA_ENTRIES;
   localparam int CW    = $clog2(SWEEP);

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_DISPATCH = 11'b000_0000_0100,
      S_LUMA     = 11'b000_0000_1000,
      S_SUM      = 11'b000_0001_0000,
      S_GR       = 11'b000_0010_0000,
      S_GG       = 11'b000_0100_0000,
      S_GB       = 11'b000_1000_0000,
      S_GW       = 11'b001_0000_0000,
      S_PWR      = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;

   logic       gray_ff, gray_in;
   logic       gamma_en_ff, gamma_en_in;
   logic [3:0] gamma_width_ff, gamma_width_in;
   logic       three_ff, three_in;
   logic       direct_ff, direct_in;

   logic [1:0]  act_ff, act_in;
   logic [7:0]  idx_ff, idx_in;
   logic [1:0]  chan_ff, chan_in;
   logic [7:0]  r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic [7:0]  gv_ff, gv_in;
   logic [23:0] prod_r_ff, prod_r_in, prod_g_ff, prod_g_in, prod_b_ff, prod_b_in;
   logic [1:0]  st_ff, st_in;
   logic        rd_show_ff, rd_show_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   logic [15:0] rsp_blue_ff, rsp_blue_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic        pal_in_range, gam_in_range, slot_free;
   logic [25:0] luma_sum;
   logic [3:0]  gw_eff, shift;
   logic [7:0]  look_val, look_raw, look_idx;

   assign pal_in_range = {1'b0, idx_ff} < 9'(PALETTE_DEPTH);
   assign gam_in_range = {1'b0, idx_ff} < 9'(GAMMA_ENTRIES);
   assign slot_free    = !rsp_valid_ff || rsp_bus.ready;
   assign luma_sum     = 26'(prod_r_ff) + 26'(prod_g_ff) + 26'(prod_b_ff);

   // Gamma index: top gamma_width bits of the byte, clamped to the table.
   assign gw_eff   = (gamma_width_ff > GAMMA_WIDTH_MAX) ? GAMMA_WIDTH_MAX : gamma_width_ff;
   assign shift    = GAMMA_WIDTH_MAX - gw_eff;
   assign look_raw = look_val >> shift;
   assign look_idx = ({1'b0, look_raw} >= 9'(GAMMA_ENTRIES)) ? 8'(GAMMA_ENTRIES - 1)
                                                             : look_raw;

   always_comb begin
      case (state_ff)
         S_GG:    look_val = g_ff;
         S_GB:    look_val = b_ff;
         default: look_val = r_ff;
      endcase
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   always_comb begin
      gray_in        = gray_ff;
      gamma_en_in    = gamma_en_ff;
      gamma_width_in = gamma_width_ff;
      three_in       = three_ff;
      direct_in      = direct_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_GRAY_MAPPING:  gray_in        = csr_bus.data[0];
            CSR_GAMMA_ENABLE:  gamma_en_in    = csr_bus.data[0];
            CSR_GAMMA_WIDTH:   gamma_width_in = csr_bus.data;
            CSR_THREE_CHANNEL: three_in       = csr_bus.data[0];
            CSR_DIRECT_MODE:   direct_in      = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      act_in     = act_ff;
      idx_in     = idx_ff;
      chan_in    = chan_ff;
      r_in       = r_ff;
      g_in       = g_ff;
      b_in       = b_ff;
      gv_in      = gv_ff;
      prod_r_in  = prod_r_ff;
      prod_g_in  = prod_g_ff;
      prod_b_in  = prod_b_ff;
      st_in      = st_ff;
      rd_show_in = rd_show_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_status_in = rsp_status_ff;

      pal_port.wr_en     = 1'b0;
      pal_port.wr_index  = idx_ff;
      pal_port.wr_data   = {r_ff, g_ff, b_ff};
      pal_port.rd_index  = idx_ff;
      gamma_port.wr_en    = 3'b000;
      gamma_port.wr_index = idx_ff;
      gamma_port.wr_data  = gv_ff;
      gamma_port.rd_table = TBL_RED;
      gamma_port.rd_index = look_idx;

      unique case (state_ff)
         S_CLEAR: begin
            // Palette to zero and every gamma table to a linear ramp.
            pal_port.wr_en      = 9'(clr_cnt_ff) < 9'(PALETTE_DEPTH);
            pal_port.wr_index   = 8'(clr_cnt_ff);
            pal_port.wr_data    = '0;
            gamma_port.wr_en    = {3{9'(clr_cnt_ff) < 9'(GAMMA_ENTRIES)}};
            gamma_port.wr_index = 8'(clr_cnt_ff);
            gamma_port.wr_data  = 8'(clr_cnt_ff);
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CW'(SWEEP - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               act_in     = req_bus.action;
               idx_in     = req_bus.index;
               chan_in    = req_bus.channel;
               r_in       = req_bus.red_in[15:8];
               g_in       = req_bus.green_in[15:8];
               b_in       = req_bus.blue_in[15:8];
               gv_in      = req_bus.gamma_value;
               st_in      = STATUS_OK;
               rd_show_in = 1'b0;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (act_ff)
               ACT_GAMMA_WR: begin
                  if (chan_ff <= TBL_BLUE && gam_in_range) begin
                     gamma_port.wr_en = 3'b001 << chan_ff;
                  end
               end
               ACT_PAL_WR: begin
                  if (direct_ff) begin
                     st_in = STATUS_WR_REJ;
                  end else if (pal_in_range) begin
                     if (gray_ff) begin
                        state_in = S_LUMA;
                     end else if (gamma_en_ff) begin
                        state_in = S_GR;
                     end else begin
                        state_in = S_PWR;
                     end
                  end
               end
               ACT_PAL_RD: begin
                  if (direct_ff) begin
                     st_in = STATUS_RD_REJ;
                  end else if (pal_in_range) begin
                     // The palette read issued this cycle lands in S_DONE.
                     rd_show_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_LUMA: begin
            prod_r_in = 24'(r_ff) * 24'(LUMA_R);
            prod_g_in = 24'(g_ff) * 24'(LUMA_G);
            prod_b_in = 24'(b_ff) * 24'(LUMA_B);
            state_in  = S_SUM;
         end
         S_SUM: begin
            r_in     = luma_sum[23:16];
            g_in     = luma_sum[23:16];
            b_in     = luma_sum[23:16];
            state_in = gamma_en_ff ? S_GR : S_PWR;
         end
         S_GR: begin
            gamma_port.rd_table = TBL_RED;
            state_in = S_GG;
         end
         S_GG: begin
            gamma_port.rd_table = three_ff ? TBL_GREEN : TBL_RED;
            r_in     = gamma_rd_data;
            state_in = S_GB;
         end
         S_GB: begin
            gamma_port.rd_table = three_ff ? TBL_BLUE : TBL_RED;
            g_in     = gamma_rd_data;
            state_in = S_GW;
         end
         S_GW: begin
            b_in     = gamma_rd_data;
            state_in = S_PWR;
         end
         S_PWR: begin
            pal_port.wr_en = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rd_show_ff) begin
               r_in = pal_rd_data[23:16];
               g_in = pal_rd_data[15:8];
               b_in = pal_rd_data[7:0];
            end
            rd_show_in = 1'b0;
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               if (rd_show_ff) begin
                  rsp_red_in   = {pal_rd_data[23:16], pal_rd_data[23:16]};
                  rsp_green_in = {pal_rd_data[15:8], pal_rd_data[15:8]};
                  rsp_blue_in  = {pal_rd_data[7:0], pal_rd_data[7:0]};
               end else begin
                  rsp_red_in   = '0;
                  rsp_green_in = '0;
                  rsp_blue_in  = '0;
               end
               state_in = S_IDLE;
            end else begin
               // Keep the read data once it has been captured.
               rd_show_in = rd_show_ff;
               r_in       = r_ff;
               g_in       = g_ff;
               b_in       = b_ff;
               if (rd_show_ff) begin
                  // Re-read would give the same word; hold the capture in the colour bytes.
                  rd_show_in = 1'b0;
                  r_in       = pal_rd_data[23:16];
                  g_in       = pal_rd_data[15:8];
                  b_in       = pal_rd_data[7:0];
                  st_in      = st_ff;
               end
            end
            if (!rd_show_ff && act_ff == ACT_PAL_RD && st_ff == STATUS_OK && pal_in_range
                && slot_free) begin
               rsp_red_in   = {r_ff, r_ff};
               rsp_green_in = {g_ff, g_ff};
               rsp_blue_in  = {b_ff, b_ff};
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_cnt_ff     <= '0;
         gray_ff        <= 1'b0;
         gamma_en_ff    <= 1'b0;
         gamma_width_ff <= GAMMA_WIDTH_MAX;
         three_ff       <= 1'b0;
         direct_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rd_show_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         gray_ff        <= gray_in;
         gamma_en_ff    <= gamma_en_in;
         gamma_width_ff <= gamma_width_in;
         three_ff       <= three_in;
         direct_ff      <= direct_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_show_ff     <= rd_show_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      idx_ff        <= idx_in;
      chan_ff       <= chan_in;
      r_ff          <= r_in;
      g_ff          <= g_in;
      b_ff          <= b_in;
      gv_ff         <= gv_in;
      prod_r_ff     <= prod_r_in;
      prod_g_ff     <= prod_g_in;
      prod_b_ff     <= prod_b_in;
      st_ff         <= st_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.red_out   = rsp_red_ff;
   assign rsp_bus.green_out = rsp_green_ff;
   assign rsp_bus.blue_out  = rsp_blue_ff;
   assign rsp_bus.status    = rsp_status_ff;

endmodule

FILE: sv/palette_gamma_clut.sv
// A gamma write, a rejected or empty word and a palette read go from dispatch straight to the done
// state; a palette write adds the luma and sum states with gray mapping, the gamma lookup states
// with gamma on, and the palette write state. One word at a time, taken only in the idle state.
// Reset (synchronous) starts a clearing pass over max(PALETTE_DEPTH, GAMMA_ENTRIES) entries that
// zeroes the palette and loads linear gamma ramps; requests wait, configuration writes are taken.
module palette_gamma_clut #(
   parameter int PALETTE_DEPTH = pgc_pkg::PGC_PALETTE_DEPTH,
   parameter int GAMMA_ENTRIES = pgc_pkg::PGC_GAMMA_ENTRIES
) (
   input  logic      clock,
   input  logic      reset,
   pgc_req_if.sink   req_bus,
   pgc_rsp_if.source rsp_bus,
   pgc_csr_if.sink   csr_bus
);
   import pgc_pkg::*;

   pal_port_type   pal_port;
   gamma_port_type gamma_port;
   logic [23:0]    pal_rd_data;
   logic [7:0]     gamma_rd_data;

   pgc_seq #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .GAMMA_ENTRIES (GAMMA_ENTRIES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .pal_port      (pal_port),
      .pal_rd_data   (pal_rd_data),
      .gamma_port    (gamma_port),
      .gamma_rd_data (gamma_rd_data)
   );

   pgc_palette_mem #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette_mem (
      .clock   (clock),
      .port_in (pal_port),
      .rd_data (pal_rd_data)
   );

   pgc_gamma_mem #(
      .GAMMA_ENTRIES (GAMMA_ENTRIES)
   ) u_gamma_mem (
      .clock   (clock),
      .port_in (gamma_port),
      .rd_data (gamma_rd_data)
   );

`ifndef SYNTHESIS
   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (!pal_port.wr_en && gamma_port.wr_en == 3'b000))
      else $error("memory write while waiting for a request");

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while a word is in flight");

   a_reject_has_no_colour: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != STATUS_OK) |->
         (rsp_bus.red_out == 16'd0 && rsp_bus.green_out == 16'd0 &&
          rsp_bus.blue_out == 16'd0))
      else $error("rejected response carries colour");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_bus.ready)
      else $error("request ready before the clearing pass");
`endif

endmodule

FILE: tb/sv/palette_gamma_clut_checker.sv
// Checker for the palette and gamma lookup table: watches the channels, predicts and compares.
module palette_gamma_clut_checker (
   input  logic clock,
   input  logic reset,
   pgc_req_if   req_bus,
   pgc_rsp_if   rsp_bus,
   pgc_csr_if   csr_bus,
   output int   fail_count,
   output int   owed_count,
   output int   word_count,
   output int   reject_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import pgc_pkg::*;

   localparam logic [15:0] BYTE_WIDEN = 16'h0101;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [1:0]  status;
   } clut_rsp_type;

   logic [7:0] pal_red   [PGC_PALETTE_DEPTH];
   logic [7:0] pal_green [PGC_PALETTE_DEPTH];
   logic [7:0] pal_blue  [PGC_PALETTE_DEPTH];
   logic [7:0] gamma_tbl [3][PGC_GAMMA_ENTRIES];

   logic       gray_on;
   logic       gamma_on;
   logic [3:0] gamma_bits;
   logic       three_tables;
   logic       direct_on;

   clut_rsp_type owed_rsp [$];
   int           fails;
   int           words;
   int           rejects;

   function automatic logic [7:0] gamma_map(logic [1:0] tbl, logic [7:0] v);
      int w;
      int pos;
      w = (gamma_bits > GAMMA_WIDTH_MAX) ? 8 : int'(gamma_bits);
      pos = int'(v) >> (8 - w);
      if (pos >= PGC_GAMMA_ENTRIES) pos = PGC_GAMMA_ENTRIES - 1;
      return gamma_tbl[tbl][pos];
   endfunction

   // Updates the shadow tables for one request word and returns the response it owes.
   function automatic clut_rsp_type apply_clut_request(logic [1:0] act, logic [7:0] idx,
         logic [1:0] chan, logic [15:0] r16, logic [15:0] g16, logic [15:0] b16,
         logic [7:0] gval);
      clut_rsp_type rsp;
      logic [7:0]   r;
      logic [7:0]   g;
      logic [7:0]   b;
      logic [31:0]  luma;
      rsp = '0;
      r = r16[15:8];
      g = g16[15:8];
      b = b16[15:8];
      case (act)
         ACT_GAMMA_WR: begin
            if (chan inside {TBL_RED, TBL_GREEN, TBL_BLUE} && int'(idx) < PGC_GAMMA_ENTRIES)
               gamma_tbl[chan][idx] = gval;
         end
         ACT_PAL_WR: begin
            if (direct_on) begin
               rsp.status = STATUS_WR_REJ;
            end else if (int'(idx) < PGC_PALETTE_DEPTH) begin
               if (gray_on) begin
                  luma = (32'(r) * LUMA_R + 32'(g) * LUMA_G + 32'(b) * LUMA_B) >> 16;
                  r = luma[7:0];
                  g = luma[7:0];
                  b = luma[7:0];
               end
               if (gamma_on) begin
                  r = gamma_map(TBL_RED, r);
                  g = gamma_map(three_tables ? TBL_GREEN : TBL_RED, g);
                  b = gamma_map(three_tables ? TBL_BLUE : TBL_RED, b);
               end
               pal_red[idx]   = r;
               pal_green[idx] = g;
               pal_blue[idx]  = b;
            end
         end
         ACT_PAL_RD: begin
            if (direct_on) begin
               rsp.status = STATUS_RD_REJ;
            end else if (int'(idx) < PGC_PALETTE_DEPTH) begin
               rsp.red   = 16'(pal_red[idx]) * BYTE_WIDEN;
               rsp.green = 16'(pal_green[idx]) * BYTE_WIDEN;
               rsp.blue  = 16'(pal_blue[idx]) * BYTE_WIDEN;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         fails++;
         $display("%t %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      clut_rsp_type want;
      if (reset) begin
         for (int i = 0; i < PGC_PALETTE_DEPTH; i++) begin
            pal_red[i]   = '0;
            pal_green[i] = '0;
            pal_blue[i]  = '0;
         end
         for (int t = 0; t < 3; t++)
            for (int i = 0; i < PGC_GAMMA_ENTRIES; i++) gamma_tbl[t][i] = 8'(i);
         gray_on      = 1'b0;
         gamma_on     = 1'b0;
         gamma_bits   = GAMMA_WIDTH_MAX;
         three_tables = 1'b0;
         direct_on    = 1'b0;
         owed_rsp.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_GRAY_MAPPING:  gray_on      = csr_bus.data[0];
               CSR_GAMMA_ENABLE:  gamma_on     = csr_bus.data[0];
               CSR_GAMMA_WIDTH:   gamma_bits   = csr_bus.data;
               CSR_THREE_CHANNEL: three_tables = csr_bus.data[0];
               CSR_DIRECT_MODE:   direct_on    = csr_bus.data[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            owed_rsp.push_back(apply_clut_request(req_bus.action, req_bus.index,
               req_bus.channel, req_bus.red_in, req_bus.green_in, req_bus.blue_in,
               req_bus.gamma_value));
         if (rsp_bus.valid && rsp_bus.ready) begin
            words++;
            if (owed_rsp.size() == 0) begin
               fails++;
               $display("%t response word with no request outstanding: %s %h %h %h %h",
                  $time, "expected none, actual", rsp_bus.red_out, rsp_bus.green_out,
                  rsp_bus.blue_out, rsp_bus.status);
            end else begin
               want = owed_rsp.pop_front();
               if (want.status != STATUS_OK) rejects++;
               compare_field("red_out", want.red, rsp_bus.red_out);
               compare_field("green_out", want.green, rsp_bus.green_out);
               compare_field("blue_out", want.blue, rsp_bus.blue_out);
               compare_field("status", 16'(want.status), 16'(rsp_bus.status));
            end
         end
      end
      fail_count   <= fails;
      owed_count   <= owed_rsp.size();
      word_count   <= words;
      reject_count <= rejects;
   end

endmodule

FILE: tb/sv/palette_gamma_clut_tb.sv
// Testbench top for the palette and gamma lookup table: clock, reset, stimulus and verdict.
module palette_gamma_clut_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pgc_pkg::*;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 24;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_WORDS   = 75;
   // A select with no gamma table behind it.
   localparam logic [1:0] TBL_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   bit   hold_off_req;
   bit   hold_done;
   int   cycle_count;
   int   settings_used;
   int   fail_count;
   int   owed_count;
   int   word_count;
   int   reject_count;

   pgc_req_if req_bus ();
   pgc_rsp_if rsp_bus ();
   pgc_csr_if csr_bus ();

   palette_gamma_clut i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   palette_gamma_clut_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_bus      (csr_bus),
      .fail_count   (fail_count),
      .owed_count   (owed_count),
      .word_count   (word_count),
      .reject_count (reject_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: random stalls, and once a long hold-off so that the block backs up.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) begin
               @(posedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_word(logic [1:0] act, logic [7:0] idx, logic [1:0] chan,
         logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [7:0] gval);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.index       <= idx;
      req_bus.channel     <= chan;
      req_bus.red_in      <= r;
      req_bus.green_in    <= g;
      req_bus.blue_in     <= b;
      req_bus.gamma_value <= gval;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [3:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // Settings change only once every owed response word has come back.
   task automatic apply_settings(logic gray, logic gamma, logic [3:0] width, logic three,
         logic direct);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      write_reg(CSR_GRAY_MAPPING, 4'(gray));
      write_reg(CSR_GAMMA_ENABLE, 4'(gamma));
      write_reg(CSR_GAMMA_WIDTH, width);
      write_reg(CSR_THREE_CHANNEL, 4'(three));
      write_reg(CSR_DIRECT_MODE, 4'(direct));
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic send_random_burst(int words);
      logic [7:0] idx;
      logic [1:0] chan;
      int         n;
      n = 0;
      while (n < words) begin
         // Low entries half the time, so that reads meet earlier writes and narrow
         // gamma tables see their loaded entries.
         idx = ($urandom_range(1) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
         case ($urandom_range(9))
            0, 1: begin
               chan = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(TBL_BLUE));
               send_word(ACT_GAMMA_WR, idx, chan, 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom));
               n++;
            end
            2, 3, 4, 5, 6: begin
               send_word(ACT_PAL_WR, idx, 2'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom));
               send_word(ACT_PAL_RD, idx, 2'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom));
               n += 2;
            end
            7, 8: begin
               send_word(ACT_PAL_RD, idx, 2'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom));
               n++;
            end
            default: begin
               send_word(2'($urandom), 8'($urandom), 2'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 8'($urandom));
               n++;
            end
         endcase
      end
   endtask

   task automatic run_directed();
      send_word(ACT_PAL_RD, 8'd0, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_PAL_WR, 8'd0, TBL_RED, 16'hffff, 16'h0000, 16'h8080, 8'h00);
      send_word(ACT_PAL_RD, 8'd0, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_PAL_WR, 8'd255, TBL_BLUE, 16'h00ff, 16'hff00, 16'hffff, 8'hff);
      send_word(ACT_PAL_RD, 8'd255, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_GAMMA_WR, 8'd0, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'hff);
      send_word(ACT_GAMMA_WR, 8'd255, TBL_GREEN, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_GAMMA_WR, 8'd128, TBL_BLUE, 16'h0000, 16'h0000, 16'h0000, 8'h5a);
      send_word(ACT_GAMMA_WR, 8'd7, TBL_NONE, 16'h0000, 16'h0000, 16'h0000, 8'haa);
      send_word(ACT_NONE, 8'hff, TBL_NONE, 16'hffff, 16'hffff, 16'hffff, 8'hff);

      apply_settings(1'b0, 1'b1, 4'd8, 1'b1, 1'b0);
      send_word(ACT_PAL_WR, 8'd1, TBL_RED, 16'hffff, 16'hffff, 16'h8000, 8'h00);
      send_word(ACT_PAL_RD, 8'd1, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_PAL_WR, 8'd2, TBL_RED, 16'h0000, 16'h00ff, 16'h7fff, 8'h00);
      send_word(ACT_PAL_RD, 8'd2, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);

      // Gray mapping with a gamma width above eight and the shared table.
      apply_settings(1'b1, 1'b1, 4'd15, 1'b0, 1'b0);
      send_word(ACT_PAL_WR, 8'd3, TBL_RED, 16'hffff, 16'hffff, 16'hffff, 8'h00);
      send_word(ACT_PAL_RD, 8'd3, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_PAL_WR, 8'd4, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_PAL_RD, 8'd4, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);

      // Direct colour: palette access is refused, gamma loads still go through.
      apply_settings(1'b0, 1'b0, 4'd8, 1'b0, 1'b1);
      send_word(ACT_PAL_WR, 8'd5, TBL_RED, 16'hffff, 16'hffff, 16'hffff, 8'h00);
      send_word(ACT_PAL_RD, 8'd5, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_GAMMA_WR, 8'd1, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h33);

      // A gamma width of zero sends every lookup to entry zero.
      apply_settings(1'b0, 1'b1, 4'd0, 1'b0, 1'b0);
      send_word(ACT_PAL_WR, 8'd6, TBL_RED, 16'h1234, 16'h5678, 16'h9abc, 8'h00);
      send_word(ACT_PAL_RD, 8'd6, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(ACT_PAL_RD, 8'd5, TBL_RED, 16'h0000, 16'h0000, 16'h0000, 8'h00);
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.action      <= ACT_NONE;
      req_bus.index       <= '0;
      req_bus.channel     <= TBL_RED;
      req_bus.red_in      <= '0;
      req_bus.green_in    <= '0;
      req_bus.blue_in     <= '0;
      req_bus.gamma_value <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= CSR_GRAY_MAPPING;
      csr_bus.data        <= '0;
      req_idle_pct = 34;
      rsp_idle_pct = 61;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES / 3) begin
            req_idle_pct = 61;
            rsp_idle_pct = 34;
         end else if (p == 2 * RANDOM_PHASES / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (p)
            0: apply_settings(1'b0, 1'b1, 4'd8, 1'b1, 1'b0);
            1: apply_settings(1'b1, 1'b1, 4'd1, 1'b0, 1'b0);
            2: apply_settings(1'b0, 1'b1, 4'd0, 1'b1, 1'b0);
            3: apply_settings(1'b1, 1'b1, 4'd15, 1'b1, 1'b0);
            4: apply_settings(1'b0, 1'b0, 4'd8, 1'b0, 1'b1);
            default: apply_settings(1'($urandom), ($urandom_range(3) != 0),
                        4'($urandom), 1'($urandom), ($urandom_range(6) == 0));
         endcase
         if (p == RANDOM_PHASES - 2) hold_off_req = 1'b1;
         send_random_burst(PHASE_WORDS);
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d response words over %0d table settings, %0d refused in direct mode.",
         word_count, settings_used, reject_count);
      $display("Traffic ran under both idling patterns, without idling and across a %0d-cycle hold-off.",
         HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
